/* rtl/core/sm3_pkg.sv */
// sm3_pkg: shared types, constants and round functions of the sm3 hash core
// used by sm3_compress and sm3_hash_top; no dependencies
package sm3_pkg;

  localparam int unsigned BlkWords = 16;
  localparam int unsigned BlkAw    = 4;
  localparam int unsigned CvWords  = 8;
  localparam int unsigned CvAw     = 3;
  localparam int unsigned RndW     = 6;
  localparam int unsigned MsgCntW  = 61;
  localparam int unsigned FillW    = 6;

  localparam logic [7:0]  PadByte  = 8'h80;
  localparam logic [31:0] TjLow    = 32'h79CC4519;
  localparam logic [31:0] TjHigh   = 32'h7A879D8A;

  // word slots of the final block
  localparam logic [BlkAw-1:0] LenHiIdx = BlkAw'(14);
  localparam logic [BlkAw-1:0] LenLoIdx = BlkAw'(15);
  localparam logic [BlkAw:0]   ZeroEndOne = (BlkAw + 1)'(14);
  localparam logic [BlkAw:0]   ZeroEndTwo = (BlkAw + 1)'(16);

  typedef logic [31:0] word_t;

  // memory requests and completion from the compression unit
  typedef struct packed {
    logic [BlkAw-1:0] blk_raddr;
    logic [CvAw-1:0]  cv_raddr;
    logic             cv_we;
    logic [CvAw-1:0]  cv_waddr;
    word_t            cv_wdata;
    logic             done;
  } cf_port_t;

  function automatic word_t rotl(word_t x, logic [4:0] n);
    logic [63:0] dbl;
    dbl = {x, x} << n;
    return dbl[63:32];
  endfunction

  function automatic word_t p0(word_t x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic word_t p1(word_t x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

  // round constant rotated by the round number
  function automatic word_t tj_rot(logic [RndW-1:0] rnd);
    word_t t;
    t = (rnd[5:4] == 2'b00) ? TjLow : TjHigh;
    return rotl(t, rnd[4:0]);
  endfunction

  // standard initial value
  function automatic word_t cv_iv(logic [CvAw-1:0] idx);
    word_t r;
    unique case (idx)
      3'd0: r = 32'h7380166F;
      3'd1: r = 32'h4914B2B9;
      3'd2: r = 32'h172442D7;
      3'd3: r = 32'hDA8A0600;
      3'd4: r = 32'hA96F30BC;
      3'd5: r = 32'h163138AA;
      3'd6: r = 32'hE38DEE4D;
      3'd7: r = 32'hB0FB0E4E;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/sm3_if.sv */
// sm3_if: valid/ready channel interfaces of the sm3 hash core
// message byte channel and digest word channel; no dependencies
interface sm3_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       has_byte;
  logic       end_of_message;

  modport source (output valid, data_byte, has_byte, end_of_message, input ready);
  modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sm3_dig_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

/* rtl/core/sm3_ram.sv */
// sm3_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
module sm3_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/sm3_compress.sv */
// sm3_compress: sm3 compression unit, one round per cycle with a 16-word
// expansion window; reads block and chaining memories, writes back the fold
// depends on sm3_pkg
module sm3_compress import sm3_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  word_t    blk_rdata_i,
  input  word_t    cv_rdata_i,
  output cf_port_t cf_o
);

  typedef enum logic [1:0] {P_IDLE, P_LOAD, P_ROUND, P_FOLD} phase_e;

  phase_e          phase_q;
  logic [RndW-1:0] cnt_q;
  word_t           w_q [BlkWords];
  word_t           v_q [CvWords];

  word_t a12, ss1, ss2, ff, gg, tt1, tt2, w_new;

  // round datapath
  always_comb begin
    a12 = rotl(v_q[0], 5'd12);
    ss1 = rotl(a12 + v_q[4] + tj_rot(cnt_q), 5'd7);
    ss2 = ss1 ^ a12;
    if (cnt_q[5:4] == 2'b00) begin
      ff = v_q[0] ^ v_q[1] ^ v_q[2];
      gg = v_q[4] ^ v_q[5] ^ v_q[6];
    end else begin
      ff = (v_q[0] & v_q[1]) | (v_q[0] & v_q[2]) | (v_q[1] & v_q[2]);
      gg = (v_q[4] & v_q[5]) | (~v_q[4] & v_q[6]);
    end
    tt1   = ff + v_q[3] + ss2 + (w_q[0] ^ w_q[4]);
    tt2   = gg + v_q[7] + ss1 + w_q[0];
    w_new = p1(w_q[0] ^ w_q[7] ^ rotl(w_q[13], 5'd15)) ^ rotl(w_q[3], 5'd7) ^ w_q[10];
  end

  // memory requests: load reads both stores, fold reads and writes chaining
  always_comb begin
    cf_o           = '0;
    cf_o.blk_raddr = cnt_q[BlkAw-1:0];
    cf_o.cv_raddr  = cnt_q[CvAw-1:0];
    cf_o.cv_waddr  = CvAw'(cnt_q - RndW'(1));
    cf_o.cv_wdata  = cv_rdata_i ^ v_q[0];
    cf_o.cv_we     = (phase_q == P_FOLD) && (cnt_q != '0);
    cf_o.done      = (phase_q == P_FOLD) && (cnt_q == RndW'(CvWords));
  end

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= P_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (phase_q)
        P_IDLE: begin
          if (start_i) begin
            phase_q <= P_LOAD;
            cnt_q   <= '0;
          end
        end
        P_LOAD: begin
          if (cnt_q == RndW'(BlkWords)) begin
            phase_q <= P_ROUND;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + RndW'(1);
          end
        end
        P_ROUND: begin
          if (cnt_q == '1) begin
            phase_q <= P_FOLD;
          end
          cnt_q <= cnt_q + RndW'(1);
        end
        P_FOLD: begin
          if (cnt_q == RndW'(CvWords)) begin
            phase_q <= P_IDLE;
            cnt_q   <= '0;
          end else begin
            cnt_q <= cnt_q + RndW'(1);
          end
        end
        default: phase_q <= P_IDLE;
      endcase
    end
  end

  // working registers and expansion window
  always_ff @(posedge clk_i) begin
    unique case (phase_q)
      P_LOAD: begin
        if (cnt_q != '0) begin
          for (int j = 0; j < BlkWords - 1; j++) begin
            w_q[j] <= w_q[j+1];
          end
          w_q[BlkWords-1] <= blk_rdata_i;
          if (cnt_q <= RndW'(CvWords)) begin
            for (int j = 0; j < CvWords - 1; j++) begin
              v_q[j] <= v_q[j+1];
            end
            v_q[CvWords-1] <= cv_rdata_i;
          end
        end
      end
      P_ROUND: begin
        v_q[0] <= tt1;
        v_q[1] <= v_q[0];
        v_q[2] <= rotl(v_q[1], 5'd9);
        v_q[3] <= v_q[2];
        v_q[4] <= p0(tt2);
        v_q[5] <= v_q[4];
        v_q[6] <= rotl(v_q[5], 5'd19);
        v_q[7] <= v_q[6];
        for (int j = 0; j < BlkWords - 1; j++) begin
          w_q[j] <= w_q[j+1];
        end
        w_q[BlkWords-1] <= w_new;
      end
      P_FOLD: begin
        if (cnt_q != '0) begin
          for (int j = 0; j < CvWords - 1; j++) begin
            v_q[j] <= v_q[j+1];
          end
          v_q[CvWords-1] <= v_q[0];
        end
      end
      default: ;
    endcase
  end

  // a new block only starts on an idle unit
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> phase_q == P_IDLE)
    else $error("compression started while busy");

  // fold never writes the entry it is reading in the same cycle
  a_fold_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cf_o.cv_we |-> cf_o.cv_waddr != cf_o.cv_raddr)
    else $error("fold read and write hit the same entry");

endmodule

/* rtl/core/sm3_hash_top.sv */
// message: a byte is taken whenever the core is idle; one that fills the block starts
// the shared round unit and holds the channel through load, rounds and fold into chaining memory
// closing: padding and length writes, one or two compressions, then each digest word is
// read, loaded and held until taken; no bytes are taken while a compression runs
// reset: asynchronous, clears counters and chaining valid bits (initial value reads)
// sm3_hash_top: sm3 hash core; depends on sm3_pkg, sm3_if, sm3_ram, sm3_compress
module sm3_hash_top import sm3_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  sm3_msg_if.sink   msg_i,
  sm3_dig_if.source dig_o
);

  typedef enum logic [3:0] {
    S_IDLE, S_COMP, S_PAD, S_ZERO, S_LEN_HI, S_LEN_LO, S_EMIT_RD, S_EMIT_LD, S_EMIT_WAIT
  } state_e;

  state_e               state_q, state_d, after_q, after_d;
  logic [FillW-1:0]     fill_q, fill_d;
  logic [MsgCntW-1:0]   cnt_q, cnt_d;
  logic [BlkAw:0]       widx_q, widx_d;
  logic                 two_q, two_d;
  logic [CvAw-1:0]      eidx_q, eidx_d;
  logic [CvWords-1:0]   cv_vld_q, cv_vld_d;
  logic                 out_vld_q, out_vld_d;
  logic [23:0]          part_q, part_d;
  word_t                out_word_q, out_word_d;

  logic                 blk_we;
  logic [BlkAw-1:0]     blk_waddr;
  word_t                blk_wdata, blk_rdata;
  logic [CvAw-1:0]      cv_raddr, cv_raddr_q;
  logic                 cv_iv_q;
  word_t                cv_ram_rdata, cv_rdata;
  logic                 cf_start;
  cf_port_t             cf;
  word_t                pad_word;
  logic [63:0]          bit_len;

  // block store and chaining value memories
  sm3_ram #(.Width(32), .Depth(BlkWords)) u_blk_ram (
    .clk_i   (clk_i),
    .we_i    (blk_we),
    .waddr_i (blk_waddr),
    .wdata_i (blk_wdata),
    .raddr_i (cf.blk_raddr),
    .rdata_o (blk_rdata)
  );

  sm3_ram #(.Width(32), .Depth(CvWords)) u_cv_ram (
    .clk_i   (clk_i),
    .we_i    (cf.cv_we),
    .waddr_i (cf.cv_waddr),
    .wdata_i (cf.cv_wdata),
    .raddr_i (cv_raddr),
    .rdata_o (cv_ram_rdata)
  );

  sm3_compress u_compress (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cf_start),
    .blk_rdata_i (blk_rdata),
    .cv_rdata_i  (cv_rdata),
    .cf_o        (cf)
  );

  // chaining entries not written since the last message read as the initial value
  assign cv_raddr = (state_q == S_COMP) ? cf.cv_raddr : eidx_q;
  assign cv_rdata = cv_iv_q ? cv_iv(cv_raddr_q) : cv_ram_rdata;

  always_ff @(posedge clk_i) begin
    cv_raddr_q <= cv_raddr;
    cv_iv_q    <= !cv_vld_q[cv_raddr];
    part_q     <= part_d;
    out_word_q <= out_word_d;
  end

  // word holding the 0x80 marker after the buffered bytes
  always_comb begin
    unique case (fill_q[1:0])
      2'd0: pad_word = {PadByte, 24'h0};
      2'd1: pad_word = {part_q[7:0], PadByte, 16'h0};
      2'd2: pad_word = {part_q[15:0], PadByte, 8'h0};
      2'd3: pad_word = {part_q[23:0], PadByte};
    endcase
  end

  assign bit_len = {cnt_q, 3'b000};

  // control: byte buffering, padding, compression hand-off, digest readout
  always_comb begin
    state_d    = state_q;
    after_d    = after_q;
    fill_d     = fill_q;
    cnt_d      = cnt_q;
    widx_d     = widx_q;
    two_d      = two_q;
    eidx_d     = eidx_q;
    cv_vld_d   = cv_vld_q;
    out_vld_d  = out_vld_q;
    part_d     = part_q;
    out_word_d = out_word_q;
    blk_we     = 1'b0;
    blk_waddr  = fill_q[FillW-1:2];
    blk_wdata  = '0;
    cf_start   = 1'b0;

    if (cf.cv_we) begin
      cv_vld_d[cf.cv_waddr] = 1'b1;
    end

    unique case (state_q)
      S_IDLE: begin
        if (msg_i.valid) begin
          if (msg_i.has_byte) begin
            if (fill_q[1:0] == 2'd3) begin
              blk_we    = 1'b1;
              blk_wdata = {part_q, msg_i.data_byte};
            end
            part_d = {part_q[15:0], msg_i.data_byte};
            fill_d = fill_q + FillW'(1);
            cnt_d  = cnt_q + MsgCntW'(1);
          end
          if (msg_i.has_byte && (fill_q == '1)) begin
            cf_start = 1'b1;
            state_d  = S_COMP;
            after_d  = msg_i.end_of_message ? S_PAD : S_IDLE;
          end else if (msg_i.end_of_message) begin
            state_d = S_PAD;
          end
        end
      end
      S_COMP: begin
        if (cf.done) begin
          state_d = after_q;
        end
      end
      S_PAD: begin
        blk_we    = 1'b1;
        blk_wdata = pad_word;
        widx_d    = {1'b0, fill_q[FillW-1:2]} + (BlkAw + 1)'(1);
        two_d     = (fill_q[FillW-1:3] == '1);
        state_d   = S_ZERO;
      end
      S_ZERO: begin
        if (widx_q < (two_q ? ZeroEndTwo : ZeroEndOne)) begin
          blk_we    = 1'b1;
          blk_waddr = widx_q[BlkAw-1:0];
          widx_d    = widx_q + (BlkAw + 1)'(1);
        end else if (two_q) begin
          cf_start = 1'b1;
          two_d    = 1'b0;
          widx_d   = '0;
          after_d  = S_ZERO;
          state_d  = S_COMP;
        end else begin
          state_d = S_LEN_HI;
        end
      end
      S_LEN_HI: begin
        blk_we    = 1'b1;
        blk_waddr = LenHiIdx;
        blk_wdata = bit_len[63:32];
        state_d   = S_LEN_LO;
      end
      S_LEN_LO: begin
        blk_we    = 1'b1;
        blk_waddr = LenLoIdx;
        blk_wdata = bit_len[31:0];
        cf_start  = 1'b1;
        after_d   = S_EMIT_RD;
        state_d   = S_COMP;
      end
      S_EMIT_RD: begin
        state_d = S_EMIT_LD;
      end
      S_EMIT_LD: begin
        out_word_d = cv_rdata;
        out_vld_d  = 1'b1;
        state_d    = S_EMIT_WAIT;
      end
      S_EMIT_WAIT: begin
        if (dig_o.ready) begin
          out_vld_d = 1'b0;
          if (eidx_q == '1) begin
            eidx_d   = '0;
            fill_d   = '0;
            cnt_d    = '0;
            cv_vld_d = '0;
            state_d  = S_IDLE;
          end else begin
            eidx_d  = eidx_q + CvAw'(1);
            state_d = S_EMIT_RD;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      after_q   <= S_IDLE;
      fill_q    <= '0;
      cnt_q     <= '0;
      widx_q    <= '0;
      two_q     <= 1'b0;
      eidx_q    <= '0;
      cv_vld_q  <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      after_q   <= after_d;
      fill_q    <= fill_d;
      cnt_q     <= cnt_d;
      widx_q    <= widx_d;
      two_q     <= two_d;
      eidx_q    <= eidx_d;
      cv_vld_q  <= cv_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  // ports
  assign msg_i.ready       = (state_q == S_IDLE);
  assign dig_o.valid       = out_vld_q;
  assign dig_o.digest_word = out_word_q;
  assign dig_o.word_index  = eidx_q;
  assign dig_o.last_word   = (eidx_q == '1);

  // chaining memory is only written back while a compression runs
  a_cv_write_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cf.cv_we |-> state_q == S_COMP)
    else $error("chaining write outside compression");

  // block store is never written while the compression unit reads it
  a_blk_no_write_in_comp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    blk_we |-> state_q != S_COMP)
    else $error("block store written during compression");

  // the last digest transaction returns the core to a fresh message
  a_fresh_after_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dig_o.valid && dig_o.ready && dig_o.last_word) |=>
      (fill_q == '0 && cnt_q == '0 && cv_vld_q == '0))
    else $error("context not cleared after digest");

endmodule

/* tb/tb_sm3_hash_top.sv */
// tb_sm3_hash_top: self-checking testbench of the sm3 hash core, directed table then random messages
// predicts every digest word in its own sm3 model and checks the word channel transaction by transaction
// depends on sm3_pkg, sm3_if and sm3_hash_top
`timescale 1ns / 100ps

module tb_sm3_hash_top;
  import sm3_pkg::*;

  localparam int unsigned ClkPeriod  = 20;
  localparam int unsigned RandItems  = 380;
  // idle limit covers two compressions plus padding, with stall and gap on top
  localparam int unsigned IdleLimit  = 3000;
  localparam int unsigned TailCycles = 300;
  localparam int unsigned MaxPrints  = 40;
  localparam int unsigned DirN       = 16;

  localparam logic [255:0] InitVec =
    256'h7380166F_4914B2B9_172442D7_DA8A0600_A96F30BC_163138AA_E38DEE4D_B0FB0E4E;

  typedef struct packed {
    logic [7:0] data;
    logic       has;
    logic       eom;
  } msg_item_t;

  typedef struct packed {
    word_t      word;
    logic [2:0] idx;
    logic       last;
  } digest_exp_t;

  // directed rows, every one checked against the digest predictor
  localparam msg_item_t DirRows [DirN] = '{
    '{8'h00, 1'b0, 1'b0},   // idle transaction, nothing happens
    '{8'h00, 1'b0, 1'b1},   // empty message right after reset
    '{8'hFF, 1'b0, 1'b1},   // empty again, data ignored without a byte
    '{8'h61, 1'b1, 1'b0},   // "abc", last byte and close together
    '{8'h62, 1'b1, 1'b0},
    '{8'h63, 1'b1, 1'b1},
    '{8'h00, 1'b1, 1'b0},   // byte extremes
    '{8'hFF, 1'b1, 1'b0},
    '{8'hA5, 1'b0, 1'b0},   // no byte inside a message
    '{8'h80, 1'b1, 1'b0},
    '{8'h7F, 1'b1, 1'b0},
    '{8'h5A, 1'b0, 1'b1},   // close without a byte
    '{8'hFF, 1'b1, 1'b1},   // one-byte messages, then a two-byte one
    '{8'h00, 1'b1, 1'b1},
    '{8'h01, 1'b1, 1'b0},
    '{8'hFE, 1'b1, 1'b1}
  };

  logic clk;
  logic rst_n;

  sm3_msg_if msg_bus ();
  sm3_dig_if dig_bus ();

  sm3_hash_top dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .msg_i (msg_bus),
    .dig_o (dig_bus)
  );

  // predictor state
  word_t         chain_q [CvWords];
  logic [7:0]    blk_q [64];
  int unsigned   fill_q;
  logic [60:0]   nbytes_q;
  digest_exp_t   digest_fifo [$];
  digest_exp_t   head_w;
  int unsigned   err_cnt;
  int unsigned   idle_cnt;
  int unsigned   burst_left;

  function automatic word_t rot_left(word_t x, int unsigned n);
    int unsigned s;
    s = n % 32;
    if (s == 0) return x;
    return (x << s) | (x >> (32 - s));
  endfunction

  function automatic word_t perm_mix0(word_t x);
    return x ^ rot_left(x, 9) ^ rot_left(x, 17);
  endfunction

  function automatic word_t perm_mix1(word_t x);
    return x ^ rot_left(x, 15) ^ rot_left(x, 23);
  endfunction

  // one 64-round compression of the block store into the chaining value
  function automatic void compress_store();
    word_t w [68];
    word_t a, b, c, d, e, f, g, h;
    word_t tj, a12, ss1, ss2, ff, gg, tt1, tt2;
    int unsigned i;
    for (i = 0; i < 16; i++) begin
      w[i] = {blk_q[4*i], blk_q[4*i+1], blk_q[4*i+2], blk_q[4*i+3]};
    end
    for (i = 16; i < 68; i++) begin
      w[i] = perm_mix1(w[i-16] ^ w[i-9] ^ rot_left(w[i-3], 15)) ^
             rot_left(w[i-13], 7) ^ w[i-6];
    end
    a = chain_q[0]; b = chain_q[1]; c = chain_q[2]; d = chain_q[3];
    e = chain_q[4]; f = chain_q[5]; g = chain_q[6]; h = chain_q[7];
    for (i = 0; i < 64; i++) begin
      tj  = (i < 16) ? TjLow : TjHigh;
      a12 = rot_left(a, 12);
      ss1 = rot_left(a12 + e + rot_left(tj, i), 7);
      ss2 = ss1 ^ a12;
      if (i < 16) begin
        ff = a ^ b ^ c;
        gg = e ^ f ^ g;
      end else begin
        ff = (a & b) | (a & c) | (b & c);
        gg = (e & f) | (~e & g);
      end
      tt1 = ff + d + ss2 + (w[i] ^ w[i+4]);
      tt2 = gg + h + ss1 + w[i];
      d = c;
      c = rot_left(b, 9);
      b = a;
      a = tt1;
      h = g;
      g = rot_left(f, 19);
      f = e;
      e = perm_mix0(tt2);
    end
    chain_q[0] ^= a; chain_q[1] ^= b; chain_q[2] ^= c; chain_q[3] ^= d;
    chain_q[4] ^= e; chain_q[5] ^= f; chain_q[6] ^= g; chain_q[7] ^= h;
  endfunction

  function automatic void restart_digest();
    int unsigned i;
    for (i = 0; i < CvWords; i++) chain_q[i] = InitVec[255 - 32*i -: 32];
    fill_q   = 0;
    nbytes_q = '0;
  endfunction

  // absorb one accepted transaction, queue the digest words on a close
  function automatic void absorb_item(msg_item_t it);
    int unsigned pos;
    int unsigned i;
    logic [63:0] bitlen;
    if (it.has) begin
      blk_q[fill_q] = it.data;
      fill_q++;
      nbytes_q++;
      if (fill_q == 64) begin
        compress_store();
        fill_q = 0;
      end
    end
    if (!it.eom) return;
    bitlen = {nbytes_q, 3'b000};
    pos = fill_q;
    blk_q[pos] = PadByte;
    pos++;
    // padding spills into a second block
    if (pos > 56) begin
      while (pos < 64) begin
        blk_q[pos] = 8'h00;
        pos++;
      end
      compress_store();
      pos = 0;
    end
    while (pos < 56) begin
      blk_q[pos] = 8'h00;
      pos++;
    end
    for (i = 0; i < 8; i++) blk_q[56 + i] = bitlen[63 - 8*i -: 8];
    compress_store();
    for (i = 0; i < CvWords; i++) begin
      digest_fifo.push_back('{chain_q[i], 3'(i), (i == 7)});
    end
    restart_digest();
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    err_cnt++;
    if (err_cnt <= MaxPrints) begin
      $display("%0t ns: %s mismatch, got %h expected %h", $time, what, got, want);
    end
  endtask

  // clock
  initial begin
    clk = 1'b0;
    forever #(ClkPeriod / 2) clk = ~clk;
  end

  // digest word checker
  always @(posedge clk) begin
    if (rst_n && dig_bus.valid && dig_bus.ready) begin
      if (digest_fifo.size() == 0) begin
        report_mismatch("unexpected digest word", dig_bus.digest_word, 32'h0);
      end else begin
        head_w = digest_fifo.pop_front();
        if (dig_bus.digest_word !== head_w.word)
          report_mismatch("digest_word", dig_bus.digest_word, head_w.word);
        if (dig_bus.word_index !== head_w.idx)
          report_mismatch("word_index", 32'(dig_bus.word_index), 32'(head_w.idx));
        if (dig_bus.last_word !== head_w.last)
          report_mismatch("last_word", 32'(dig_bus.last_word), 32'(head_w.last));
      end
    end
  end

  // cycles without any transaction on either channel
  always @(posedge clk) begin
    if ((msg_bus.valid && msg_bus.ready) || (dig_bus.valid && dig_bus.ready))
      idle_cnt <= 0;
    else
      idle_cnt <= idle_cnt + 1;
  end

  initial begin : watchdog
    idle_cnt = 0;
    @(posedge clk);
    while (idle_cnt < IdleLimit) @(posedge clk);
    $display("tb_sm3_hash_top: FAIL");
    $finish;
  end

  // receiver stall pattern: free running, random, rotating mask, long stalls
  initial begin : rx_stall
    int unsigned mode;
    int unsigned span;
    int unsigned k;
    logic [7:0]  mask;
    dig_bus.ready <= 1'b0;
    forever begin
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 150);
      mask = 8'($urandom) | 8'h01;
      for (k = 0; k < span; k++) begin
        @(posedge clk);
        case (mode)
          0: dig_bus.ready <= 1'b1;
          1: dig_bus.ready <= 1'($urandom_range(0, 1));
          2: dig_bus.ready <= mask[k % 8];
          default: dig_bus.ready <= ((k % 16) >= 12);
        endcase
      end
    end
  end

  function automatic int unsigned next_burst();
    if ($urandom_range(0, 3) == 0) return $urandom_range(100, 300);
    return $urandom_range(1, 12);
  endfunction

  // one transaction on the message channel, then burst pacing
  task automatic send_item(msg_item_t it);
    int unsigned gap;
    msg_bus.valid          <= 1'b1;
    msg_bus.data_byte      <= it.data;
    msg_bus.has_byte       <= it.has;
    msg_bus.end_of_message <= it.eom;
    @(posedge clk);
    while (!msg_bus.ready) @(posedge clk);
    absorb_item(it);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? $urandom_range(8, 20) : $urandom_range(1, 4);
      msg_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = next_burst();
    end
  endtask

  // hold the sender until every queued digest word has come back
  task automatic drain_digests();
    msg_bus.valid <= 1'b0;
    @(posedge clk);
    while (digest_fifo.size() != 0) @(posedge clk);
  endtask

  // message length, mostly short, with the padding boundaries hit often
  function automatic int unsigned pick_len();
    int unsigned sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0, 1, 2, 3: return $urandom_range(0, 20);
      4: return $urandom_range(0, 3);
      5, 6: begin
        sel = $urandom_range(0, 5);
        return (sel < 3) ? 55 + sel : 60 + sel;
      end
      7: return $urandom_range(21, 70);
      8: return $urandom_range(110, 130);
      default: begin
        sel = $urandom_range(0, 4);
        return (sel < 3) ? 119 + sel : 124 + sel;
      end
    endcase
  endfunction

  // random message with occasional idle transactions mixed in
  task automatic send_message(int unsigned len, output int unsigned used);
    int unsigned k;
    logic        close_with_byte;
    msg_item_t   it;
    close_with_byte = (len != 0) && ($urandom_range(0, 1) == 1);
    used = 0;
    for (k = 0; k < len; k++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_item('{8'($urandom), 1'b0, 1'b0});
        used++;
      end
      it.data = 8'($urandom);
      it.has  = 1'b1;
      it.eom  = close_with_byte && (k == len - 1);
      send_item(it);
      used++;
    end
    if (!close_with_byte) begin
      send_item('{8'($urandom), 1'b0, 1'b1});
      used++;
    end
  endtask

  // main stimulus
  initial begin : stimulus
    int unsigned r;
    int unsigned sent;
    int unsigned used;
    err_cnt = 0;
    restart_digest();
    burst_left = next_burst();
    rst_n                  <= 1'b0;
    msg_bus.valid          <= 1'b0;
    msg_bus.data_byte      <= 8'h00;
    msg_bus.has_byte       <= 1'b0;
    msg_bus.end_of_message <= 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (r = 0; r < DirN; r++) send_item(DirRows[r]);
    drain_digests();

    sent = 0;
    while (sent < RandItems) begin
      send_message(pick_len(), used);
      sent += used;
      if ($urandom_range(0, 5) == 0) drain_digests();
    end

    // wait for the last digest words, then watch for anything extra
    msg_bus.valid <= 1'b0;
    while (digest_fifo.size() != 0) @(posedge clk);
    repeat (TailCycles) @(posedge clk);
    if (err_cnt == 0)
      $display("tb_sm3_hash_top: PASS");
    else
      $display("tb_sm3_hash_top: FAIL");
    $finish;
  end

endmodule

/* sim.f */
rtl/core/sm3_pkg.sv
rtl/core/sm3_if.sv
rtl/core/sm3_ram.sv
rtl/core/sm3_compress.sv
rtl/core/sm3_hash_top.sv
tb/tb_sm3_hash_top.sv
